// ===== rtl/mjh_pkg.sv =====
// Package for the masked joint histogram core: operation codes, register
// indexes, field widths and the clear sweep status type.
// No dependencies.
`default_nettype none

package mjh_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int LABEL_BITS     = 8;
   localparam int BIN_ADDR_BITS  = 16;
   localparam int VALUE_BITS     = 24;
   localparam int OP_BITS        = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [VALUE_BITS-1:0] CUT_HIGH = VALUE_BITS'(255);

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR = 2'd0,
      OP_ACCUM = 2'd1,
      OP_READ  = 2'd2
   } mjh_op_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS_SELECT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WHOLE_IMAGE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIRRORED      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUT_ENABLE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CUT_THRESHOLD = 3'd4;

   typedef struct packed {
      logic                     active;
      logic [BIN_ADDR_BITS-1:0] addr;
   } mjh_sweep_type;

endpackage

`default_nettype wire

// ===== rtl/mjh_if.sv =====
// Channel interfaces: request (operation and pixel fields) and response
// (bin value), each with valid/ready. Depends on mjh_pkg.
`default_nettype none

interface mjh_req_if
   import mjh_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [OP_BITS-1:0]       operation;
   logic [PIXEL_BITS-1:0]    pixel_a;
   logic [PIXEL_BITS-1:0]    pixel_b;
   logic [LABEL_BITS-1:0]    class_label;
   logic [BIN_ADDR_BITS-1:0] bin_index;

   modport source (output valid, operation, pixel_a, pixel_b, class_label, bin_index,
                   input ready);
   modport sink   (input valid, operation, pixel_a, pixel_b, class_label, bin_index,
                   output ready);
endinterface

interface mjh_rsp_if
   import mjh_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] bin_value;

   modport source (output valid, bin_value, input ready);
   modport sink   (input valid, bin_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/masked_joint_histogram_2d_core.sv =====
// Masked joint histogram core: 256x256 saturating pixel-pair counts.
// Accumulate and read take one transfer per cycle unless a clear sweep, a clear item or a
// held response stalls req; a read result goes through the bin RAM read register, then
// the output register, to rsp. A clear item blocks requests while every bin is zeroed.
// Synchronous reset initialises the control registers and starts a zeroing sweep
// of the bin RAM; requests are refused until it ends. Depends on mjh_pkg, mjh_if.
`default_nettype none

module masked_joint_histogram_2d_core
   import mjh_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   mjh_req_if.sink                        req_chan,
   mjh_rsp_if.source                      rsp_chan,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (COUNT_BITS > VALUE_BITS) ? COUNT_BITS : VALUE_BITS;

   // configuration
   logic [LABEL_BITS-1:0] class_select_ff;
   logic                  whole_image_ff;
   logic                  mirrored_ff;
   logic                  cut_enable_ff;
   logic [VALUE_BITS-1:0] cut_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_select_ff  <= '0;
         whole_image_ff   <= 1'b1;
         mirrored_ff      <= 1'b0;
         cut_enable_ff    <= 1'b0;
         cut_threshold_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLASS_SELECT:  class_select_ff  <= csr_write_data[LABEL_BITS-1:0];
            CSR_WHOLE_IMAGE:   whole_image_ff   <= csr_write_data[0];
            CSR_MIRRORED:      mirrored_ff      <= csr_write_data[0];
            CSR_CUT_ENABLE:    cut_enable_ff    <= csr_write_data[0];
            CSR_CUT_THRESHOLD: cut_threshold_ff <= csr_write_data[VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   mjh_sweep_type            sweep;
   mjh_op_type               req_op;
   logic                     req_xfer;
   logic                     req_inc;
   logic [BIN_ADDR_BITS-1:0] acc_addr;
   logic [BIN_ADDR_BITS-1:0] rd_addr;

   assign req_xfer = req_chan.valid & req_chan.ready;
   assign req_op   = mjh_op_type'(req_chan.operation);
   assign req_inc  = whole_image_ff | (req_chan.class_label == class_select_ff);
   assign acc_addr = mirrored_ff ? {~req_chan.pixel_a, ~req_chan.pixel_b}
                                 : {~req_chan.pixel_b, req_chan.pixel_a};
   assign rd_addr  = (req_op == OP_READ) ? req_chan.bin_index : acc_addr;

   // stage 1: RAM data returned, modify
   logic                     s1_valid_ff, s1_valid_in;
   mjh_op_type               s1_op_ff;
   logic                     s1_inc_ff;
   logic [BIN_ADDR_BITS-1:0] s1_addr_ff;
   logic [COUNT_BITS-1:0]    ram_rd_data;
   logic [COUNT_BITS-1:0]    s1_count;
   logic [COUNT_BITS-1:0]    s1_next;
   logic                     s1_write;
   logic                     s1_is_read;
   logic                     s1_stall;
   logic                     s1_clear;

   // last write, forwarded over the read-before-write RAM
   logic                     lw_valid_ff;
   logic [BIN_ADDR_BITS-1:0] lw_addr_ff;
   logic [COUNT_BITS-1:0]    lw_data_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [CMP_BITS-1:0]   count_ext;
   logic [CMP_BITS-1:0]   thr_ext;
   logic [VALUE_BITS-1:0] read_value;

   assign s1_count   = (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : ram_rd_data;
   assign s1_next    = (s1_count == '1) ? s1_count : s1_count + 1'b1;
   assign s1_write   = s1_valid_ff && (s1_op_ff == OP_ACCUM) && s1_inc_ff;
   assign s1_is_read = s1_valid_ff && (s1_op_ff == OP_READ);
   assign s1_clear   = s1_valid_ff && (s1_op_ff == OP_CLEAR);
   assign s1_stall   = s1_is_read && rsp_valid_ff && !rsp_chan.ready;

   assign req_chan.ready = !sweep.active && !s1_clear && !s1_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (!s1_stall) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff   <= req_op;
         s1_inc_ff  <= req_inc;
         s1_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (sweep.active) begin
         lw_valid_ff <= 1'b0;
      end else if (s1_write) begin
         lw_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= s1_next;
      end
   end

   mjh_clear_seq u_clear_seq (
      .clock (clock),
      .reset (reset),
      .start (s1_clear),
      .sweep (sweep)
   );

   mjh_bin_ram #(
      .ADDR_BITS (BIN_ADDR_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (sweep.active | s1_write),
      .wr_addr (sweep.active ? sweep.addr : s1_addr_ff),
      .wr_data (sweep.active ? '0 : s1_next),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // read result, optional cut
   assign count_ext = CMP_BITS'(s1_count);
   assign thr_ext   = CMP_BITS'(cut_threshold_ff);

   always_comb begin
      if (cut_enable_ff) begin
         read_value = (count_ext <= thr_ext) ? '0 : CUT_HIGH;
      end else begin
         read_value = count_ext[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_is_read && !s1_stall) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_is_read && !s1_stall) begin
         rsp_value_ff <= read_value;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bin_value = rsp_value_ff;

   // checks
   a_no_req_during_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep.active |-> !req_xfer)
      else $error("request transfer during clear sweep");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(sweep.active && s1_write))
      else $error("accumulate write during clear sweep");

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_clear |=> sweep.active)
      else $error("clear item did not start sweep");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_is_read))
      else $error("response without read item");

endmodule

`default_nettype wire

// ===== rtl/mjh_bin_ram.sv =====
// Bin store: simple dual-port synchronous RAM, one write and one registered
// read per cycle, read-before-write. No dependencies.
`default_nettype none

module mjh_bin_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mjh_clear_seq.sv =====
// Clear sweep sequencer: walks every bin address once after reset and after
// a clear item. Depends on mjh_pkg.
`default_nettype none

module mjh_clear_seq
   import mjh_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output mjh_sweep_type      sweep
);

   logic                     active_ff, active_in;
   logic [BIN_ADDR_BITS-1:0] addr_ff, addr_in;

   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (start) begin
         active_in = 1'b1;
         addr_in   = '0;
      end else if (active_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == '1) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   assign sweep.active = active_ff;
   assign sweep.addr   = addr_ff;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_joint_histogram_2d_core: a directed table, then random
// phases, a hold-off burst and a repeated-hit run, all checked against a bin-count predictor.
// Depends on mjh_pkg, mjh_if and the core RTL.

module tb;
   import mjh_pkg::*;

   localparam int COUNT_BITS      = 24;
   localparam int BIN_COUNT       = 1 << BIN_ADDR_BITS;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 150;
   localparam int HOT_ITEMS       = 20;

   localparam logic [OP_BITS-1:0]       OP_UNUSED = 2'd3;
   localparam logic [BIN_ADDR_BITS-1:0] HOT_BIN   = {8'd155, 8'd200};

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_BITS-1:0]  csr_sel;
      logic [CSR_DATA_BITS-1:0]   csr_data;
      logic [OP_BITS-1:0]         op;
      logic [PIXEL_BITS-1:0]      a;
      logic [PIXEL_BITS-1:0]      b;
      logic [LABEL_BITS-1:0]      label;
      logic [BIN_ADDR_BITS-1:0]   idx;
      logic                       has_known;
      logic [VALUE_BITS-1:0]      known_value;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   mjh_req_if req_bus ();
   mjh_rsp_if rsp_bus ();

   masked_joint_histogram_2d_core #(.COUNT_BITS(COUNT_BITS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [COUNT_BITS-1:0]    bin_count [BIN_COUNT];
   logic [BIN_ADDR_BITS-1:0] touched_bins [$];
   logic [VALUE_BITS-1:0]    pending_bin_values [$];
   logic [LABEL_BITS-1:0]    cfg_class_select;
   logic                     cfg_whole_image;
   logic                     cfg_mirrored;
   logic                     cfg_cut_enable;
   logic [VALUE_BITS-1:0]    cfg_cut_threshold;

   bit idle_on;
   bit hold_off_req;
   int cycle_count;
   int mismatch_count;
   int reads_checked;
   int requests_sent;
   int accums_counted;
   int clears_done;
   int csr_writes;
   logic [VALUE_BITS-1:0] expected_value;

   function automatic void clear_bins();
      foreach (bin_count[i]) bin_count[i] = '0;
      touched_bins.delete();
   endfunction

   function automatic bit histogram_apply(input logic [OP_BITS-1:0] op,
                                          input logic [PIXEL_BITS-1:0] a,
                                          input logic [PIXEL_BITS-1:0] b,
                                          input logic [LABEL_BITS-1:0] label,
                                          input logic [BIN_ADDR_BITS-1:0] idx,
                                          output logic [VALUE_BITS-1:0] value);
      logic [BIN_ADDR_BITS-1:0] bin;
      logic [COUNT_BITS-1:0]    count;
      value = '0;
      case (op)
         OP_CLEAR: begin
            clear_bins();
            clears_done++;
            return 1'b0;
         end
         OP_ACCUM: begin
            if (cfg_whole_image || label == cfg_class_select) begin
               // 255-x is the bitwise inverse of an 8-bit pixel
               bin = cfg_mirrored ? {~a, ~b} : {~b, a};
               if (bin_count[bin] != '1) bin_count[bin] = bin_count[bin] + 1'b1;
               touched_bins.push_back(bin);
               if (touched_bins.size() > 512) void'(touched_bins.pop_front());
               accums_counted++;
            end
            return 1'b0;
         end
         OP_READ: begin
            count = bin_count[idx];
            if (cfg_cut_enable)
               value = (VALUE_BITS'(count) <= cfg_cut_threshold) ? '0 : CUT_HIGH;
            else
               value = VALUE_BITS'(count);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic stim_row_type item_row(input logic [OP_BITS-1:0] op,
                                             input logic [PIXEL_BITS-1:0] a,
                                             input logic [PIXEL_BITS-1:0] b,
                                             input logic [LABEL_BITS-1:0] label,
                                             input logic [BIN_ADDR_BITS-1:0] idx,
                                             input logic has_known,
                                             input logic [VALUE_BITS-1:0] known_value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.op = op;
      row.a = a;
      row.b = b;
      row.label = label;
      row.idx = idx;
      row.has_known = has_known;
      row.known_value = known_value;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] sel,
                                            input logic [CSR_DATA_BITS-1:0] data);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr_sel = sel;
      row.csr_data = data;
      return row;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      if ($urandom_range(0, 1) == 0) return PIXEL_BITS'($urandom);
      // values near either end so that bins repeat
      return ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ PIXEL_BITS'($urandom_range(0, 3));
   endfunction

   task automatic send_item(input logic [OP_BITS-1:0] op,
                            input logic [PIXEL_BITS-1:0] a,
                            input logic [PIXEL_BITS-1:0] b,
                            input logic [LABEL_BITS-1:0] label,
                            input logic [BIN_ADDR_BITS-1:0] idx,
                            input logic has_known,
                            input logic [VALUE_BITS-1:0] known_value);
      logic [VALUE_BITS-1:0] value;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.pixel_a     <= a;
      req_bus.pixel_b     <= b;
      req_bus.class_label <= label;
      req_bus.bin_index   <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      requests_sent++;
      if (histogram_apply(op, a, b, label, idx, value))
         pending_bin_values.push_back(has_known ? known_value : value);
   endtask

   task automatic send_random_request();
      int                       pick;
      logic [OP_BITS-1:0]       op;
      logic [LABEL_BITS-1:0]    label;
      logic [BIN_ADDR_BITS-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         op = OP_UNUSED;
      else if (pick < 58)
         op = OP_ACCUM;
      else
         op = OP_READ;
      if (!cfg_whole_image && $urandom_range(0, 9) < 6)
         label = cfg_class_select;
      else
         label = LABEL_BITS'($urandom);
      if (touched_bins.size() != 0 && $urandom_range(0, 9) < 7)
         idx = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
      else
         idx = BIN_ADDR_BITS'($urandom);
      send_item(op, random_pixel(), random_pixel(), label, idx, 1'b0, '0);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_bin_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] sel,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
      case (sel)
         CSR_CLASS_SELECT:  cfg_class_select  = data[LABEL_BITS-1:0];
         CSR_WHOLE_IMAGE:   cfg_whole_image   = data[0];
         CSR_MIRRORED:      cfg_mirrored      = data[0];
         CSR_CUT_ENABLE:    cfg_cut_enable    = data[0];
         CSR_CUT_THRESHOLD: cfg_cut_threshold = data;
         default: ;
      endcase
   endtask

   // upper bits of narrow registers carry junk, which the block must drop
   task automatic configure_random();
      logic [LABEL_BITS-1:0]    sel;
      logic [CSR_DATA_BITS-1:0] thr;
      case ($urandom_range(0, 2))
         0: sel = '0;
         1: sel = '1;
         default: sel = LABEL_BITS'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: thr = '0;
         1: thr = '1;
         2: thr = CSR_DATA_BITS'($urandom);
         default: thr = CSR_DATA_BITS'($urandom_range(0, 3));
      endcase
      csr_write(CSR_CLASS_SELECT, {(CSR_DATA_BITS-LABEL_BITS)'($urandom), sel});
      csr_write(CSR_WHOLE_IMAGE, {(CSR_DATA_BITS-1)'($urandom), 1'($urandom_range(0, 1))});
      csr_write(CSR_MIRRORED, {(CSR_DATA_BITS-1)'($urandom), 1'($urandom_range(0, 1))});
      csr_write(CSR_CUT_ENABLE,
                {(CSR_DATA_BITS-1)'($urandom), 1'($urandom_range(0, 9) < 3)});
      csr_write(CSR_CUT_THRESHOLD, thr);
   endtask

   initial begin : rsp_ready_gen
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_bin_values.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: bin value %0d with no read outstanding", $realtime,
                        rsp_bus.bin_value);
            mismatch_count++;
         end else begin
            expected_value = pending_bin_values.pop_front();
            reads_checked++;
            if (rsp_bus.bin_value !== expected_value) begin
               if (mismatch_count < 10)
                  $display("%0t: bin value mismatch, expected %0d got %0d", $realtime,
                           expected_value, rsp_bus.bin_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
               pending_bin_values.size());
      $display("masked_joint_histogram_2d_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      stim_row_type          directed_rows [$];
      stim_row_type          row;
      logic [VALUE_BITS-1:0] hot_count;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_CLEAR;
      req_bus.pixel_a     = '0;
      req_bus.pixel_b     = '0;
      req_bus.class_label = '0;
      req_bus.bin_index   = '0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_CLASS_SELECT;
      csr_write_data      = '0;
      cfg_class_select    = '0;
      cfg_whole_image     = 1'b1;
      cfg_mirrored        = 1'b0;
      cfg_cut_enable      = 1'b0;
      cfg_cut_threshold   = '0;
      clear_bins();

      // corners, repeat hits, class mask, mirroring, cut, unused code, clear
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65535, 1'b1, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd255, 8'd255, 8'd255, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd255, 8'd0, 8'h55, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd0, 8'd255, 8'hAA, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65280, 1'b1, 24'd1));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd255, 1'b1, 24'd1));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65535, 1'b1, 24'd1));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1, 24'd1));
      directed_rows.push_back(item_row(OP_UNUSED, 8'd255, 8'd255, 8'd255, 16'd65535,
                                       1'b0, 24'd0));
      repeat (3)
         directed_rows.push_back(item_row(OP_ACCUM, 8'd17, 8'd34, 8'd0, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd56593, 1'b0, 24'd0));
      directed_rows.push_back(csr_row(CSR_CLASS_SELECT, 24'd200));
      directed_rows.push_back(csr_row(CSR_WHOLE_IMAGE, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd1, 8'd1, 8'd200, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd1, 8'd1, 8'd199, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65025, 1'b0, 24'd0));
      directed_rows.push_back(csr_row(CSR_MIRRORED, 24'd1));
      directed_rows.push_back(item_row(OP_ACCUM, 8'd1, 8'd1, 8'd200, 16'd0, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65278, 1'b0, 24'd0));
      directed_rows.push_back(csr_row(CSR_CUT_ENABLE, 24'd1));
      directed_rows.push_back(csr_row(CSR_CUT_THRESHOLD, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65278, 1'b1, CUT_HIGH));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd1, 1'b1, 24'd0));
      directed_rows.push_back(csr_row(CSR_CUT_THRESHOLD, 24'hFFFFFF));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1, 24'd0));
      directed_rows.push_back(csr_row(CSR_CUT_ENABLE, 24'd0));
      directed_rows.push_back(item_row(OP_CLEAR, 8'd9, 8'd9, 8'd9, 16'd9, 1'b0, 24'd0));
      directed_rows.push_back(item_row(OP_READ, 8'd0, 8'd0, 8'd0, 16'd65280, 1'b1, 24'd0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain();
            csr_write(row.csr_sel, row.csr_data);
         end else begin
            send_item(row.op, row.a, row.b, row.label, row.idx, row.has_known,
                      row.known_value);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         configure_random();
         idle_on = (p != 2 && p != RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 60) begin
               // output held off while reads keep coming: the block must back up
               idle_on = 1'b0;
               hold_off_req = 1'b1;
               repeat (40)
                  send_item(OP_READ, random_pixel(), random_pixel(), 8'($urandom),
                            16'($urandom), 1'b0, '0);
               idle_on = 1'b1;
            end
            if (p == 3 && n == 85) drain();
            if ((p == 2 || p == 4) && n == 100)
               send_item(OP_CLEAR, random_pixel(), random_pixel(), 8'($urandom),
                         16'($urandom), 1'b0, '0);
            send_random_request();
         end
         send_item(OP_READ, 8'd0, 8'd0, 8'd0, 16'($urandom), 1'b0, '0);
      end

      // repeated hits on one bin, no idling from here on
      drain();
      idle_on = 1'b0;
      csr_write(CSR_WHOLE_IMAGE, 24'd1);
      csr_write(CSR_MIRRORED, 24'd0);
      csr_write(CSR_CUT_ENABLE, 24'd0);
      for (int n = 0; n < HOT_ITEMS; n++)
         send_item(OP_ACCUM, 8'd200, 8'd100, 8'd0, 16'd0, 1'b0, '0);
      send_item(OP_READ, 8'd0, 8'd0, 8'd0, HOT_BIN, 1'b0, '0);
      drain();
      hot_count = VALUE_BITS'(bin_count[HOT_BIN]);
      csr_write(CSR_CUT_ENABLE, 24'd1);
      csr_write(CSR_CUT_THRESHOLD, hot_count - 24'd1);
      send_item(OP_READ, 8'd0, 8'd0, 8'd0, HOT_BIN, 1'b0, '0);
      drain();
      csr_write(CSR_CUT_THRESHOLD, hot_count);
      send_item(OP_READ, 8'd0, 8'd0, 8'd0, HOT_BIN, 1'b0, '0);

      drain();
      repeat (16) @(posedge clock);
      $display("%0d requests (%0d counted accumulates, %0d clears), %0d reads checked,",
               requests_sent, accums_counted, clears_done, reads_checked);
      $display("%0d register writes, %0d-bit counts; %0d mismatches in %0d cycles",
               csr_writes, COUNT_BITS, mismatch_count, cycle_count);
      if (mismatch_count == 0 && pending_bin_values.size() == 0)
         $display("masked_joint_histogram_2d_core regression: pass");
      else
         $display("masked_joint_histogram_2d_core regression: fail");
      $finish;
   end

endmodule

// ===== masked_joint_histogram_2d_core.f =====
rtl/mjh_pkg.sv
rtl/mjh_if.sv
rtl/mjh_bin_ram.sv
rtl/mjh_clear_seq.sv
rtl/masked_joint_histogram_2d_core.sv
dv/tb.sv
